### src/assert_macros.svh
// Assertion macros shared by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/cpl_pkg.sv
// Package: constants and types of the rule classifier.
package cpl_pkg;
  localparam int RuleSlots = 64;
  localparam int CacheWays = 8;
  localparam int SlotW = $clog2(RuleSlots);
  localparam int WayW = $clog2(CacheWays);
  localparam logic [5:0] OpAny = 6'd63;
  localparam logic [7:0] FmtAny = 8'd255;
  localparam int RuleW = 1 + 30 + 96 + 12;

  typedef enum logic [1:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_OUT
  } cpl_state_t;

  typedef struct packed {
    logic        func;
    logic [5:0]  slot;
    logic [5:0]  operator_code;
    logic [7:0]  source_format;
    logic [7:0]  mask_format_code;
    logic [7:0]  dest_format_code;
    logic [31:0] source_flag_bits;
    logic [31:0] mask_flag_bits;
    logic [31:0] dest_flag_bits;
    logic [7:0]  routine_id;
    logic [3:0]  provider_id;
    logic        rule_enable;
  } cpl_req_t;

  typedef struct packed {
    logic       found;
    logic       from_cache;
    logic [3:0] result_provider;
    logic [7:0] result_routine;
  } cpl_out_t;

  typedef struct packed {
    logic        found;
    logic        from_cache;
    logic [11:0] target;
  } cpl_resp_t;

  typedef struct packed {
    logic        valid;
    logic [29:0] key;
    logic [95:0] flags;
    logic [11:0] target;
  } cpl_way_t;

  function automatic logic rule_match(input logic [RuleW-1:0] r, input logic [29:0] key,
                                      input logic [95:0] fl);
    logic        en;
    logic [5:0]  op;
    logic [7:0]  sf, mf, df;
    logic [95:0] need;
    en = r[RuleW-1];
    op = r[RuleW-2 -: 6];
    sf = r[RuleW-8 -: 8];
    mf = r[RuleW-16 -: 8];
    df = r[RuleW-24 -: 8];
    need = r[107:12];
    return en && (op == OpAny || op == key[29:24]) && (sf == FmtAny || sf == key[23:16])
      && (mf == FmtAny || mf == key[15:8]) && (df == FmtAny || df == key[7:0])
      && ((need & fl) == need);
  endfunction
endpackage

### src/cpl_if.sv
// Valid/ready channel interface.
interface cpl_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### src/cpl_ram.sv
// Generic RAM with one write port and one registered read port.
module cpl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/cpl_cache.sv
// Eight-way move-to-front cache of recent lookup answers.
module cpl_cache
  import cpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        flush,
  input  logic [29:0] key,
  input  logic [95:0] flags,
  output logic        hit,
  output logic [11:0] hit_target,
  input  logic        update,
  input  logic [11:0] upd_target
);
  `include "assert_macros.svh"
  cpl_way_t way [CacheWays];
  logic [CacheWays-1:0] match;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] top;

  always_comb begin
    hit_way = '0;
    for (int w = CacheWays - 1; w >= 0; w--) begin
      match[w] = way[w].valid && way[w].key == key && way[w].flags == flags;
      if (match[w]) hit_way = WayW'(w);
    end
    hit = |match;
    hit_target = way[hit_way].target;
    top = hit ? hit_way : WayW'(CacheWays - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < CacheWays; w++) way[w] <= '0;
    end else if (flush) begin
      for (int w = 0; w < CacheWays; w++) way[w].valid <= 1'b0;
    end else if (update) begin
      for (int w = 1; w < CacheWays; w++)
        if (WayW'(w) <= top) way[w] <= way[w-1];
      way[0] <= '{valid: 1'b1, key: key, flags: flags, target: upd_target};
    end
  end

  `ASSERT_IMPLIES(a_one_hit, clk, rst, 1'b1, $onehot0(match))
  `ASSERT_NEXT(a_front_valid, clk, rst, update && !flush, way[0].valid)
  `ASSERT_NEXT(a_flush_clears, clk, rst, flush, way[0].valid == 1'b0)
endmodule

### src/composite_path_lookup_mru.sv
// Top level of the wildcard rule classifier with MRU cache.
// Each input word yields one result word, and the next input word is taken only after the
// result word has left. A load flushes the cache; a lookup that hits the cache is answered
// from it; a cache miss scans the rule memory one slot per cycle through its registered read
// port and stops at the first matching slot, or runs through all RuleSlots slots when no rule
// matches. Apart from the wait for the result to be taken, the scan length alone sets the
// time of a miss.
// Slots that were never loaded count as disabled.
module composite_path_lookup_mru
  import cpl_pkg::*;
(
  input logic clk,
  input logic rst,
  cpl_if.sink   in_ch,
  cpl_if.source out_ch
);
  `include "assert_macros.svh"
  cpl_state_t state, state_next;
  logic [29:0] req_key;
  logic [95:0] req_flags;
  cpl_resp_t  resp;
  logic [SlotW:0] scan;
  logic [SlotW:0] rd_idx;
  logic        rd_live;
  logic [RuleW-1:0] rdata, wdata;
  logic        we, hit, accept, rmatch, cache_upd, hit_upd, flush;
  logic [11:0] hit_target;
  logic [RuleSlots-1:0] rule_loaded;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.data = '{found: resp.found, from_cache: resp.from_cache,
                         result_provider: resp.target[11:8], result_routine: resp.target[7:0]};

  assign we = accept && in_ch.data.func && ({1'b0, in_ch.data.slot} < 7'(RuleSlots));
  assign wdata = {in_ch.data.rule_enable, in_ch.data.operator_code, in_ch.data.source_format,
                  in_ch.data.mask_format_code, in_ch.data.dest_format_code,
                  in_ch.data.source_flag_bits, in_ch.data.mask_flag_bits,
                  in_ch.data.dest_flag_bits, in_ch.data.provider_id, in_ch.data.routine_id};
  assign flush = accept && in_ch.data.func;

  cpl_ram #(.Width(RuleW), .Depth(RuleSlots)) u_rules (
    .clk, .we, .waddr(in_ch.data.slot[SlotW-1:0]), .wdata,
    .raddr(scan[SlotW-1:0]), .rdata
  );

  // Mark loaded slots; an unloaded slot never matches.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_loaded <= '0;
    end else if (we) begin
      rule_loaded[in_ch.data.slot] <= 1'b1;
    end
  end

  assign rmatch = rd_live && rule_loaded[rd_idx[SlotW-1:0]]
                  && rule_match(rdata, req_key, req_flags);
  assign cache_upd = (state == ST_SCAN || state == ST_DRAIN) && rmatch;
  // First scan cycle: answer from the cache when it holds the key.
  assign hit_upd = (state == ST_SCAN) && rd_idx == '1 && hit;

  cpl_cache u_cache (
    .clk, .rst, .flush, .key(req_key), .flags(req_flags), .hit, .hit_target,
    .update(cache_upd || hit_upd),
    .upd_target(rmatch ? rdata[11:0] : hit_target)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = in_ch.data.func ? ST_OUT : ST_SCAN;
      ST_SCAN: begin
        if (hit_upd) state_next = ST_OUT;
        else if (rmatch) state_next = ST_OUT;
        else if (scan == (SlotW+1)'(RuleSlots)) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan <= '0;
      rd_idx <= '1;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan <= '0;
        rd_idx <= '1;
        rd_live <= 1'b0;
      end else if (state == ST_SCAN) begin
        rd_idx <= scan;
        rd_live <= scan < (SlotW+1)'(RuleSlots);
        if (scan < (SlotW+1)'(RuleSlots)) scan <= scan + 1'b1;
      end else begin
        rd_live <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_key <= wdata[137:108];
      req_flags <= wdata[107:12];
      resp <= '{found: in_ch.data.func, from_cache: 1'b0, target: 12'd0};
    end else if (hit_upd) begin
      resp <= '{found: 1'b1, from_cache: 1'b1, target: hit_target};
    end else if ((state == ST_SCAN || state == ST_DRAIN) && rmatch) begin
      resp <= '{found: 1'b1, from_cache: 1'b0, target: rdata[11:0]};
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, clk, rst, in_ch.ready, !out_ch.valid)
  `ASSERT_NEXT(a_load_out, clk, rst, accept && in_ch.data.func, out_ch.valid && resp.found)
  `ASSERT_IMPLIES(a_miss_zero, clk, rst, out_ch.valid && !resp.found, resp.target == 12'd0)
endmodule

### tb/tb_composite_path_lookup_mru.sv
// Testbench for the rule classifier: directed and random rule loads and lookups against a scoreboard.
module tb_composite_path_lookup_mru;
  import cpl_pkg::*;

  localparam int NumRandom = 1600;
  localparam int StallLimit = 5000;
  localparam int LongHold = 300;

  // Predicts classifier answers and holds those not yet returned.
  class lookup_scoreboard;
    logic [29:0] rule_code[RuleSlots];
    logic [95:0] rule_need[RuleSlots];
    logic [11:0] rule_dest[RuleSlots];
    bit          rule_on[RuleSlots];
    cpl_way_t    way[CacheWays];
    cpl_resp_t   awaited[$];
    int errors, results, cache_answers, rule_answers, misses, loads;

    function new();
      for (int s = 0; s < RuleSlots; s++) begin
        rule_on[s] = 0;
        rule_code[s] = '0;
        rule_need[s] = '0;
        rule_dest[s] = '0;
      end
      for (int w = 0; w < CacheWays; w++) way[w] = '0;
    endfunction

    function bit fits(int s, logic [29:0] key, logic [95:0] fl);
      logic [5:0] op;
      logic [7:0] f;
      op = rule_code[s][29:24];
      if (!rule_on[s]) return 0;
      if (op != OpAny && op != key[29:24]) return 0;
      for (int i = 0; i < 3; i++) begin
        f = rule_code[s][8*i +: 8];
        if (f != FmtAny && f != key[8*i +: 8]) return 0;
      end
      return (rule_need[s] & fl) == rule_need[s];
    endfunction

    // Shift ways below top down by one and put the entry at the front.
    function void to_front(int top, logic [29:0] key, logic [95:0] fl, logic [11:0] tgt);
      for (int w = top; w > 0; w--) way[w] = way[w-1];
      way[0] = '{valid: 1'b1, key: key, flags: fl, target: tgt};
    endfunction

    function void note(cpl_req_t r);
      cpl_resp_t e;
      bit done;
      logic [29:0] key;
      logic [95:0] fl;
      e = '0;
      done = 0;
      key = {r.operator_code, r.source_format, r.mask_format_code, r.dest_format_code};
      fl = {r.source_flag_bits, r.mask_flag_bits, r.dest_flag_bits};
      if (r.func) begin
        rule_on[r.slot] = r.rule_enable;
        rule_code[r.slot] = key;
        rule_need[r.slot] = fl;
        rule_dest[r.slot] = {r.provider_id, r.routine_id};
        for (int w = 0; w < CacheWays; w++) way[w].valid = 1'b0;
        e.found = 1'b1;
        loads++;
      end else begin
        for (int w = 0; w < CacheWays && !done; w++)
          if (way[w].valid && way[w].key == key && way[w].flags == fl) begin
            e = '{found: 1'b1, from_cache: 1'b1, target: way[w].target};
            to_front(w, key, fl, way[w].target);
            cache_answers++;
            done = 1;
          end
        for (int s = 0; s < RuleSlots && !done; s++)
          if (fits(s, key, fl)) begin
            e = '{found: 1'b1, from_cache: 1'b0, target: rule_dest[s]};
            to_front(CacheWays - 1, key, fl, rule_dest[s]);
            rule_answers++;
            done = 1;
          end
        if (!done) misses++;
      end
      awaited.push_back(e);
    endfunction

    function void check(cpl_out_t a);
      cpl_resp_t e;
      logic [11:0] got;
      results++;
      got = {a.result_provider, a.result_routine};
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", a);
        return;
      end
      e = awaited.pop_front();
      if (a.found !== e.found || a.from_cache !== e.from_cache || got !== e.target) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at result %0d: expected found=%0b cache=%0b tgt=%03h, got %0b %0b %03h",
                   results, e.found, e.from_cache, e.target, a.found, a.from_cache, got);
      end
    endfunction
  endclass

  logic clk, rst;
  cpl_if #(.T(cpl_req_t)) in_ch();
  cpl_if #(.T(cpl_out_t)) out_ch();

  composite_path_lookup_mru dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  lookup_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int quiet = 0;
  cpl_req_t recent[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 20);
        out_ch.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("watchdog: no word moved for %0d cycles", StallLimit);
      $display("composite_path_lookup_mru regression: fail");
      $finish;
    end
  end

  task automatic send(cpl_req_t r);
    int n;
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note(r);
    if (!r.func) begin
      recent.push_back(r);
      if (recent.size() > 12) void'(recent.pop_front());
    end
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic cpl_req_t load_word(int s, logic [5:0] op, logic [7:0] sf,
                                         logic [7:0] mf, logic [7:0] df, logic [95:0] need,
                                         logic [11:0] tgt, bit en);
    cpl_req_t r;
    r = '0;
    r.func = 1'b1;
    r.slot = s[5:0];
    r.operator_code = op;
    r.source_format = sf;
    r.mask_format_code = mf;
    r.dest_format_code = df;
    r.source_flag_bits = need[95:64];
    r.mask_flag_bits = need[63:32];
    r.dest_flag_bits = need[31:0];
    r.routine_id = tgt[7:0];
    r.provider_id = tgt[11:8];
    r.rule_enable = en;
    return r;
  endfunction

  function automatic cpl_req_t ask_word(logic [5:0] op, logic [7:0] sf, logic [7:0] mf,
                                        logic [7:0] df, logic [95:0] fl);
    cpl_req_t r;
    r = '0;
    r.func = 1'b0;
    r.slot = 6'($urandom);
    r.operator_code = op;
    r.source_format = sf;
    r.mask_format_code = mf;
    r.dest_format_code = df;
    r.source_flag_bits = fl[95:64];
    r.mask_flag_bits = fl[63:32];
    r.dest_flag_bits = fl[31:0];
    r.routine_id = 8'($urandom);
    r.provider_id = 4'($urandom);
    r.rule_enable = 1'($urandom);
    return r;
  endfunction

  function automatic logic [95:0] rand96();
    return {$urandom, $urandom, $urandom};
  endfunction

  function automatic logic [95:0] sparse96();
    return {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom,
            $urandom & $urandom & $urandom};
  endfunction

  function automatic logic [7:0] rule_fmt();
    return ($urandom_range(0, 3) == 0) ? FmtAny : 8'($urandom_range(0, 7));
  endfunction

  // Random rule, mostly in low slots so that lookups find it.
  function automatic cpl_req_t rand_rule();
    int s;
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RuleSlots - 1) : $urandom_range(0, 15);
    return load_word(s, ($urandom_range(0, 3) == 0) ? OpAny : 6'($urandom_range(0, 7)),
                     rule_fmt(), rule_fmt(), rule_fmt(),
                     ($urandom_range(0, 2) == 0) ? '0 : sparse96(),
                     12'($urandom), $urandom_range(0, 5) != 0);
  endfunction

  // Request built to satisfy a chosen rule, or a near miss of it.
  function automatic cpl_req_t aimed_ask();
    int s;
    logic [29:0] k;
    logic [29:0] q;
    logic [95:0] fl;
    s = $urandom_range(0, 15);
    k = sb.rule_code[s];
    q[29:24] = (k[29:24] == OpAny) ? 6'($urandom) : k[29:24];
    for (int i = 0; i < 3; i++)
      q[8*i +: 8] = (k[8*i +: 8] == FmtAny) ? 8'($urandom_range(0, 7)) : k[8*i +: 8];
    fl = sb.rule_need[s] | ($urandom_range(0, 1) ? sparse96() : rand96());
    if ($urandom_range(0, 5) == 0) fl[$urandom_range(0, 95)] = 1'b0;
    if ($urandom_range(0, 7) == 0) q[$urandom_range(0, 29)] ^= 1'b1;
    return ask_word(q[29:24], q[23:16], q[15:8], q[7:0], fl);
  endfunction

  initial begin
    cpl_req_t r;
    int pick;
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table miss, routine zero, wildcards, cache hit, eviction.
    send(ask_word(6'd0, 8'd0, 8'd0, 8'd0, '0));
    send(ask_word(OpAny, FmtAny, FmtAny, FmtAny, '1));
    send(load_word(0, OpAny, FmtAny, FmtAny, FmtAny, '0, 12'hABC, 1'b0));
    send(ask_word(6'd1, 8'd2, 8'd3, 8'd4, '0));
    send(load_word(63, OpAny, FmtAny, FmtAny, FmtAny, '0, 12'h000, 1'b1));
    send(ask_word(6'd1, 8'd2, 8'd3, 8'd4, '0));
    send(ask_word(6'd1, 8'd2, 8'd3, 8'd4, '0));
    send(load_word(5, 6'd7, 8'd1, 8'd2, 8'd3, {32'h1, 32'h8000_0000, 32'hF0}, 12'hFFF, 1'b1));
    send(ask_word(6'd7, 8'd1, 8'd2, 8'd3, '1));
    send(ask_word(6'd7, 8'd1, 8'd2, 8'd3, {32'h1, 32'h8000_0000, 32'h70}));
    send(ask_word(OpAny, 8'd1, 8'd2, 8'd3, '1));
    send(ask_word(6'd7, 8'd1, 8'd2, 8'd3, '1));
    for (int i = 0; i < 9; i++) send(ask_word(6'(i), 8'(i), 8'd9, FmtAny, '1));
    send(ask_word(6'd0, 8'd0, 8'd9, FmtAny, '1));
    send(ask_word(6'd8, 8'd8, 8'd9, FmtAny, '1));
    send(load_word(63, 6'd0, 8'd0, 8'd0, 8'd0, '1, 12'h000, 1'b0));
    send(ask_word(6'd8, 8'd8, 8'd9, FmtAny, '1));

    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= NumRandom - 200);
      if (i == 500) hold_req = 1;
      if (i == 900) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) r = rand_rule();
      else if (pick < 45 && recent.size() > 0) r = recent[$urandom_range(0, recent.size() - 1)];
      else if (pick < 85) r = aimed_ask();
      else r = ask_word(6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), rand96());
      send(r);
    end
    in_ch.valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d loads, %0d cache answers, %0d rule answers, %0d misses",
             sb.loads, sb.cache_answers, sb.rule_answers, sb.misses);
    $display("checked %0d result words, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("composite_path_lookup_mru regression: pass");
    else
      $display("composite_path_lookup_mru regression: fail");
    $finish;
  end
endmodule
